@@ src/assert_macros.svh @@
// assertion macros used by the sampler top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ src/hbs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the height-map bilinear sampler
package hbs_pkg;

    // field widths
    localparam int RES_W      = 8;
    localparam int SIZE_W     = 31;
    localparam int HEIGHT_W   = 16;
    localparam int INDEX_W    = 14;
    localparam int COORD_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int POS_W      = RES_W + FRAC_W;
    localparam int DIV_STEPS  = POS_W;
    localparam int S_DATA_W   = 96;
    localparam int M_DATA_W   = 32;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes
    localparam logic [1:0] REG_GRID_RES     = 2'd0;
    localparam logic [1:0] REG_WORLD_SIZE   = 2'd1;
    localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

    // register reset values
    localparam logic [RES_W-1:0]  GRID_RES_RST     = 8'd128;
    localparam logic [SIZE_W-1:0] WORLD_SIZE_RST   = 31'd65536;
    localparam logic [SIZE_W-1:0] HEIGHT_SCALE_RST = 31'd65536;

    // word kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIVIDE,
        ST_FETCH,
        ST_BLEND,
        ST_EMIT
    } state_t;

    // corners: 0 row0/col0, 1 row0/col1, 2 row1/col0, 3 row1/col1
    typedef struct packed {
        logic [3:0][HEIGHT_W-1:0] corner;
        logic [FRAC_W-1:0]        frac_c;
        logic [FRAC_W-1:0]        frac_r;
    } blend_in_t;

endpackage

@@ src/hbs_ram.sv @@
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module hbs_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/hbs_pos_div.sv @@
`timescale 1ns / 1ps
// grid position unit: floor(num * span * 2^16 / den), one quotient bit a cycle
module hbs_pos_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [hbs_pkg::COORD_W-1:0] num,
    input  logic [hbs_pkg::RES_W-1:0]   span,
    input  logic [hbs_pkg::COORD_W-1:0] den,
    output logic                        done,
    output logic [hbs_pkg::POS_W-1:0]   quot
);
    import hbs_pkg::*;

    localparam int CNT_W  = $clog2(DIV_STEPS);
    localparam int PROD_W = COORD_W + RES_W;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COORD_W-1:0] rem_reg, rem_next;
    logic [POS_W-1:0]   sh_reg, sh_next;
    logic [PROD_W-1:0]  prod;
    logic [COORD_W:0]   trial;
    logic               ge;

    // restoring division, dividend bits shift out the top, quotient bits in
    always_comb begin
        prod      = num * span;
        trial     = {rem_reg, sh_reg[POS_W-1]};
        ge        = trial >= {1'b0, den};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        if (start) begin
            // numerator at most den, so the high part starts below den
            rem_next  = prod[PROD_W-1 -: COORD_W];
            sh_next   = {prod[RES_W-1:0], {FRAC_W{1'b0}}};
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? COORD_W'(trial - {1'b0, den}) : trial[COORD_W-1:0];
            sh_next  = {sh_reg[POS_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

@@ src/hbs_blend.sv @@
`timescale 1ns / 1ps
// bilinear blend, baseline removal and height scaling over three stages
module hbs_blend (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  hbs_pkg::blend_in_t           blend_in,
    input  logic [hbs_pkg::SIZE_W-1:0]   scale,
    output logic                         done,
    output logic [hbs_pkg::M_DATA_W-1:0] result
);
    import hbs_pkg::*;

    localparam int ACC_W  = 2 * HEIGHT_W;
    localparam int STEP_W = HEIGHT_W + FRAC_W + 2;
    localparam int ROW_W  = ACC_W + FRAC_W + 2;
    localparam int PROD_W = 2 * COORD_W;

    logic v1_reg, v2_reg, v3_reg;

    logic signed [HEIGHT_W:0]   diff_top, diff_bot;
    logic signed [STEP_W-1:0]   step_top, step_bot, sum_top, sum_bot;
    logic [ACC_W-1:0]           top_reg, bot_reg;
    logic [FRAC_W-1:0]          frac_r_reg;

    logic signed [ACC_W:0]      diff_row;
    logic signed [ROW_W-1:0]    step_row, sum_row;
    logic [ACC_W-1:0]           level;
    logic signed [COORD_W-1:0]  dev_next, dev_reg;

    logic signed [PROD_W-1:0]   prod_next, prod_reg;
    logic signed [PROD_W-1:0]   rounded;

    // first pass along columns, units of 2^-32
    always_comb begin
        diff_top = $signed({1'b0, blend_in.corner[1]}) - $signed({1'b0, blend_in.corner[0]});
        diff_bot = $signed({1'b0, blend_in.corner[3]}) - $signed({1'b0, blend_in.corner[2]});
        step_top = diff_top * $signed({1'b0, blend_in.frac_c});
        step_bot = diff_bot * $signed({1'b0, blend_in.frac_c});
        sum_top  = $signed({2'b0, blend_in.corner[0], {FRAC_W{1'b0}}}) + step_top;
        sum_bot  = $signed({2'b0, blend_in.corner[2], {FRAC_W{1'b0}}}) + step_bot;
    end

    // second pass along rows, then drop to 2^-32 and remove the baseline
    always_comb begin
        diff_row = $signed({1'b0, bot_reg}) - $signed({1'b0, top_reg});
        step_row = diff_row * $signed({1'b0, frac_r_reg});
        sum_row  = $signed({2'b0, top_reg, {FRAC_W{1'b0}}}) + step_row;
        level    = sum_row[ACC_W+FRAC_W-1:FRAC_W];
        dev_next = {~level[ACC_W-1], level[ACC_W-2:0]};
    end

    // scale by the height factor
    assign prod_next = dev_reg * $signed({1'b0, scale});

    // round half up to q16.16; product stays below 2^62 so no clipping is needed
    assign rounded = prod_reg + $signed(PROD_W'(64'h0000_0000_8000_0000));
    assign result  = rounded[PROD_W-1 -: M_DATA_W];
    assign done    = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (start) begin
            top_reg    <= sum_top[ACC_W-1:0];
            bot_reg    <= sum_bot[ACC_W-1:0];
            frac_r_reg <= blend_in.frac_r;
        end
        if (v1_reg) begin
            dev_reg <= dev_next;
        end
        if (v2_reg) begin
            prod_reg <= prod_next;
        end
    end

endmodule

@@ src/heightmap_bilinear_sampler_top.sv @@
`timescale 1ns / 1ps
// top level of the height-map bilinear sampler
// A load word writes one height entry and leaves the sequencer idle. A query
// word has its position clamped when it is accepted; then the scaled
// numerator is formed, the two bit-per-cycle position dividers (column and
// row run side by side) find the cell, the four corner heights are read
// through the one read port of the height store, and the blend, scaling and
// output register follow. A query with a resolution below two or a zero world
// size skips these steps and answers 0.
// The next word is taken once the result is in the output register, even if
// that result has not been collected yet. The height store has no reset; every
// entry that a query can touch must be loaded first.
`include "assert_macros.svh"

module heightmap_bilinear_sampler_top #(
    parameter int MAX_RESOLUTION = 128
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cell_index[13:0], height_word[29:14], local_x[61:30], local_z[93:62]
    input  logic [hbs_pkg::S_DATA_W-1:0]   s_tdata,
    // kind[0]
    input  logic [0:0]                     s_tuser,
    // result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // sampled_height[31:0]
    output logic [hbs_pkg::M_DATA_W-1:0]   m_tdata,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hbs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hbs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hbs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import hbs_pkg::*;

    localparam int GRID_DEPTH = MAX_RESOLUTION * MAX_RESOLUTION;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int GRID_W     = 2 * RES_W;
    localparam int NUM_W      = COORD_W + 3;
    localparam int HGT_LSB    = INDEX_W;
    localparam int X_LSB      = INDEX_W + HEIGHT_W;
    localparam int Z_LSB      = X_LSB + COORD_W;
    localparam int FETCH_W    = 3;
    localparam logic [FETCH_W-1:0] FETCH_LAST = 3'd4;

    // clamp a position numerator into [0, den]
    function automatic logic [COORD_W-1:0] clamp_num(input logic [NUM_W-1:0] v,
                                                     input logic [COORD_W-1:0] d);
        logic [COORD_W-1:0] r;
        if (v[NUM_W-1]) begin
            r = '0;
        end else if (v > NUM_W'(d)) begin
            r = d;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // registers
    logic [RES_W-1:0]  res_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] scale_reg;

    state_t state_reg, state_next;
    logic [FETCH_W-1:0] fetch_cnt_reg, fetch_cnt_next;
    logic               blend_go_reg, blend_go_next;
    logic               zero_reg, zero_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [COORD_W-1:0] num_c_reg, num_r_reg;
    logic [3:0][HEIGHT_W-1:0] corner_reg;

    logic               s_accept, s_kind, apb_write;
    logic [INDEX_W-1:0] s_cell_index;
    logic [HEIGHT_W-1:0] s_height;
    logic [COORD_W-1:0] s_x, s_z;
    logic [RES_W-1:0]   res_eff, span;
    logic [COORD_W-1:0] den;
    logic               degenerate;
    logic [NUM_W-1:0]   x2, z2, size_ext, num_c, num_r;

    logic               div_start, div_done_c, div_done_r;
    logic [POS_W-1:0]   q_c, q_r;
    logic [RES_W-1:0]   c0, c1, r0, r1, row, col;
    logic [GRID_W-1:0]  idx_sum;

    logic               load_we, ram_re, ram_cap, load_out, out_free;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [HEIGHT_W-1:0] rd_data;
    logic [1:0]         cap_idx;

    blend_in_t          blend_in;
    logic               blend_done;
    logic [M_DATA_W-1:0] blend_result;

    // input word fields
    assign s_kind       = s_tuser[0];
    assign s_cell_index = s_tdata[INDEX_W-1:0];
    assign s_height     = s_tdata[HGT_LSB +: HEIGHT_W];
    assign s_x          = s_tdata[X_LSB +: COORD_W];
    assign s_z          = s_tdata[Z_LSB +: COORD_W];
    assign s_accept     = s_tvalid && s_tready;

    // register port
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_GRID_RES:     prdata = APB_DATA_W'(res_reg);
            REG_WORLD_SIZE:   prdata = APB_DATA_W'(size_reg);
            REG_HEIGHT_SCALE: prdata = APB_DATA_W'(scale_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg   <= GRID_RES_RST;
            size_reg  <= WORLD_SIZE_RST;
            scale_reg <= HEIGHT_SCALE_RST;
        end else if (apb_write) begin
            case (paddr[3:2])
                REG_GRID_RES:     res_reg   <= pwdata[RES_W-1:0];
                REG_WORLD_SIZE:   size_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT_SCALE: scale_reg <= pwdata[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    // grid geometry from the registers
    always_comb begin
        res_eff    = (int'(res_reg) > MAX_RESOLUTION) ? RES_W'(MAX_RESOLUTION) : res_reg;
        span       = res_eff - RES_W'(1);
        den        = {size_reg, 1'b0};
        degenerate = (res_reg < RES_W'(2)) || (size_reg == '0);
    end

    // doubled position numerators, x + half and half - z over the full size
    always_comb begin
        x2       = {{2{s_x[COORD_W-1]}}, s_x, 1'b0};
        z2       = {{2{s_z[COORD_W-1]}}, s_z, 1'b0};
        size_ext = NUM_W'(size_reg);
        num_c    = x2 + size_ext;
        num_r    = size_ext - z2;
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            num_c_reg <= clamp_num(num_c, den);
            num_r_reg <= clamp_num(num_r, den);
        end
    end

    // column and row position lanes
    hbs_pos_div u_div_c (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_c_reg),
        .span    (span),
        .den     (den),
        .done    (div_done_c),
        .quot    (q_c)
    );

    hbs_pos_div u_div_r (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_r_reg),
        .span    (span),
        .den     (den),
        .done    (div_done_r),
        .quot    (q_r)
    );

    // cell and far neighbour limited to the grid edge
    always_comb begin
        c0      = q_c[POS_W-1:FRAC_W];
        r0      = q_r[POS_W-1:FRAC_W];
        c1      = (c0 == span) ? span : c0 + RES_W'(1);
        r1      = (r0 == span) ? span : r0 + RES_W'(1);
        row     = fetch_cnt_reg[1] ? r1 : r0;
        col     = fetch_cnt_reg[0] ? c1 : c0;
        idx_sum = GRID_W'(row) * GRID_W'(res_eff) + GRID_W'(col);
    end

    // height store accesses
    assign load_we = s_accept && (s_kind == KIND_LOAD) && (int'(s_cell_index) < GRID_DEPTH);
    assign wr_addr = ADDR_W'(s_cell_index);
    assign rd_addr = ADDR_W'(idx_sum);
    assign ram_re  = (state_reg == ST_FETCH) && (fetch_cnt_reg != FETCH_LAST);
    assign ram_cap = (state_reg == ST_FETCH) && (fetch_cnt_reg != '0);
    assign cap_idx = 2'(fetch_cnt_reg - FETCH_W'(1));

    hbs_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .clk   (aclk),
        .we    (load_we),
        .waddr (wr_addr),
        .wdata (s_height),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (ram_cap) begin
            corner_reg[cap_idx] <= rd_data;
        end
    end

    // blend datapath
    always_comb begin
        blend_in.corner = corner_reg;
        blend_in.frac_c = q_c[FRAC_W-1:0];
        blend_in.frac_r = q_r[FRAC_W-1:0];
    end

    hbs_blend u_blend (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (blend_go_reg),
        .blend_in (blend_in),
        .scale    (scale_reg),
        .done     (blend_done),
        .result   (blend_result)
    );

    // query sequencer
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        fetch_cnt_next = fetch_cnt_reg;
        zero_next      = zero_reg;
        blend_go_next  = 1'b0;
        div_start      = 1'b0;
        load_out       = 1'b0;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_accept && (s_kind == KIND_QUERY)) begin
                    zero_next  = degenerate;
                    state_next = degenerate ? ST_EMIT : ST_PREP;
                end
            end
            ST_PREP: begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_done_c) begin
                    fetch_cnt_next = '0;
                    state_next     = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (fetch_cnt_reg == FETCH_LAST) begin
                    blend_go_next = 1'b1;
                    state_next    = ST_BLEND;
                end else begin
                    fetch_cnt_next = fetch_cnt_reg + FETCH_W'(1);
                end
            end
            ST_BLEND: begin
                if (blend_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fetch_cnt_reg <= '0;
            blend_go_reg  <= 1'b0;
            zero_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fetch_cnt_reg <= fetch_cnt_next;
            blend_go_reg  <= blend_go_next;
            zero_reg      <= zero_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= zero_reg ? '0 : blend_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `ASSERT_NEVER(a_lanes_agree, aclk, aresetn, div_done_c != div_done_r, "position lanes out of step")
    `ASSERT_IMPL(a_div_in_state, aclk, aresetn, div_done_c |-> state_reg == ST_DIVIDE, "divider finished outside divide")
    `ASSERT_IMPL(a_blend_in_state, aclk, aresetn, blend_done |-> state_reg == ST_BLEND, "blend finished outside blend")
    `ASSERT_IMPL(a_emit_loads, aclk, aresetn, state_reg == ST_EMIT && !m_tvalid_reg |=> m_tvalid_reg, "result not loaded")

endmodule

@@ sim/hbs_height_checker.sv @@
`timescale 1ns / 1ps
// checker that mirrors the sampler's store and registers and compares every height word
module hbs_height_checker #(
    parameter int MAX_RES = 128
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // cell_index[13:0], height_word[29:14], local_x[61:30], local_z[93:62]
    input  logic [hbs_pkg::S_DATA_W-1:0]   s_tdata,
    // kind[0]
    input  logic [0:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // sampled_height[31:0]
    input  logic [hbs_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [hbs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hbs_pkg::APB_DATA_W-1:0] pwdata,
    output int                             mismatch_count,
    output int                             owed_count
);
    import hbs_pkg::*;

    localparam int GRID_DEPTH = MAX_RES * MAX_RES;

    logic [RES_W-1:0]    grid_res;
    logic [SIZE_W-1:0]   world_size;
    logic [SIZE_W-1:0]   height_scale;
    logic [HEIGHT_W-1:0] height_store [GRID_DEPTH];
    logic [M_DATA_W-1:0] owed_heights [$];

    initial begin
        mismatch_count = 0;
        owed_count     = 0;
        foreach (height_store[i]) height_store[i] = '0;
    end

    // fixed-point grid position: clamped numerator times span over den, 16 fraction bits
    function automatic longint unsigned cell_position(input longint num, input longint den,
                                                      input longint unsigned span);
        longint clamped;
        clamped = (num < 0) ? 64'sd0 : ((num > den) ? den : num);
        return (($unsigned(clamped) * span) << 16) / $unsigned(den);
    endfunction

    function automatic longint grid_word(input int unsigned row, input int unsigned col,
                                         input int unsigned res);
        int unsigned idx;
        idx = row * res + col;
        if (idx >= GRID_DEPTH) return 0;
        return longint'(height_store[idx]);
    endfunction

    // bilinear blend of the four corners, rebased and scaled to q16.16
    function automatic logic [M_DATA_W-1:0] predict_height(input logic signed [31:0] px,
                                                           input logic signed [31:0] pz);
        int unsigned res, span, c0, r0, c1, r1;
        longint den, fc, fr, upper, lower, blend, rel, prod, q;
        longint unsigned cp, rp, biased;
        res = grid_res;
        if (res < 2 || world_size == 0) return '0;
        if (res > MAX_RES) res = MAX_RES;
        span = res - 1;
        den  = 2 * longint'(world_size);
        cp = cell_position(2 * longint'(px) + longint'(world_size), den, span);
        rp = cell_position(longint'(world_size) - 2 * longint'(pz), den, span);
        c0 = cp >> 16;
        r0 = rp >> 16;
        fc = cp & 64'hFFFF;
        fr = rp & 64'hFFFF;
        c1 = (c0 + 1 > span) ? span : c0 + 1;
        r1 = (r0 + 1 > span) ? span : r0 + 1;
        // column pass in units of 2^-32, row pass in units of 2^-48
        upper = grid_word(r0, c0, res) * 65536
              + (grid_word(r0, c1, res) - grid_word(r0, c0, res)) * fc;
        lower = grid_word(r1, c0, res) * 65536
              + (grid_word(r1, c1, res) - grid_word(r1, c0, res)) * fc;
        blend = upper * 65536 + (lower - upper) * fr;
        rel   = (blend >>> 16) - 64'sd2147483648;
        prod  = rel * longint'(height_scale);
        // round half up, then saturate to 32 bits
        biased = $unsigned(prod + 64'sd2147483648 + 64'sd4611686018427387904);
        q = $signed(biased >> 32) - 64'sd1073741824;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%t: %s", $realtime, msg);
    endtask

    // watch registers, input words and result words
    always @(posedge aclk) begin
        if (!aresetn) begin
            grid_res     = GRID_RES_RST;
            world_size   = WORLD_SIZE_RST;
            height_scale = HEIGHT_SCALE_RST;
            owed_heights.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_GRID_RES:     grid_res     = pwdata[RES_W-1:0];
                    REG_WORLD_SIZE:   world_size   = pwdata[SIZE_W-1:0];
                    REG_HEIGHT_SCALE: height_scale = pwdata[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == KIND_LOAD) begin
                    if (s_tdata[13:0] < GRID_DEPTH) height_store[s_tdata[13:0]] = s_tdata[29:14];
                end else begin
                    owed_heights.push_back(predict_height(s_tdata[61:30], s_tdata[93:62]));
                end
            end
            if (m_tvalid && m_tready) begin
                if (owed_heights.size() == 0) begin
                    log_mismatch($sformatf("height word %h with none outstanding", m_tdata));
                end else if (owed_heights[0] !== m_tdata) begin
                    log_mismatch($sformatf("sampled_height expected %h actual %h",
                                           owed_heights[0], m_tdata));
                    void'(owed_heights.pop_front());
                end else begin
                    void'(owed_heights.pop_front());
                end
            end
        end
        owed_count = owed_heights.size();
    end

endmodule

@@ sim/tb_heightmap_bilinear_sampler_top.sv @@
`timescale 1ns / 1ps
// stimulus, clock, reset and verdict for the height-map bilinear sampler
module tb_heightmap_bilinear_sampler_top;
    import hbs_pkg::*;

    localparam int         MAX_RES       = 128;
    localparam int         GRID_DEPTH    = MAX_RES * MAX_RES;
    localparam int         RANDOM_ITEMS  = 1250;
    localparam int         IDLE_PCT      = 11;
    localparam int         CHOKE_CYCLES  = 400;
    localparam int         SETTLE_CYCLES = 50;
    localparam int         STALL_LIMIT   = 5000;
    localparam logic [1:0] REG_SPARE     = 2'd3;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          mismatches;
    int          owed;
    int unsigned gap_pct   = IDLE_PCT;
    bit          rx_steady = 1'b0;
    bit          choke_req = 1'b0;
    int unsigned cur_res   = 128;
    longint      cur_size  = 65536;

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    heightmap_bilinear_sampler_top #(
        .MAX_RESOLUTION(MAX_RES)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hbs_height_checker #(
        .MAX_RES(MAX_RES)
    ) height_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatch_count(mismatches),
        .owed_count    (owed)
    );

    // offer one word, with random idle cycles ahead of it
    task automatic send_word(input logic kind, input logic [INDEX_W-1:0] idx,
                             input logic [HEIGHT_W-1:0] h, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] z);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_DATA_W'({z, x, h, idx});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load_height(input logic [INDEX_W-1:0] idx, input logic [HEIGHT_W-1:0] h);
        send_word(KIND_LOAD, idx, h, $urandom, $urandom);
    endtask

    task automatic ask_height(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] z);
        send_word(KIND_QUERY, $urandom, $urandom, x, z);
    endtask

    // stop offering and let every outstanding height come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (owed != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // setup cycle then access cycle
    task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(input logic [31:0] res_w, input logic [31:0] size_w,
                                 input logic [31:0] scale_w);
        wait_idle();
        reg_write(REG_GRID_RES, res_w);
        reg_write(REG_WORLD_SIZE, size_w);
        reg_write(REG_HEIGHT_SCALE, scale_w);
        cur_res  = res_w[RES_W-1:0];
        cur_size = size_w[SIZE_W-1:0];
    endtask

    // mostly inside the terrain, some near its edges, some anywhere
    function automatic logic [COORD_W-1:0] pick_coord(input longint side);
        longint      half, v;
        int unsigned sel;
        half = side / 2;
        sel  = $urandom_range(99);
        if (sel < 60) v = longint'($urandom_range(side)) - half;
        else if (sel < 75) v = ($urandom_range(1) ? half : -half) + $urandom_range(8) - 4;
        else if (sel < 95) v = $urandom;
        else v = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
        return v[31:0];
    endfunction

    // random register setting, with junk in the unused upper bits
    task automatic random_setting();
        int unsigned sel;
        logic [31:0] res_w, size_w, scale_w;
        res_w   = $urandom;
        size_w  = $urandom;
        scale_w = $urandom;
        sel = $urandom_range(99);
        if (sel < 10) res_w[7:0] = 8'd2;
        else if (sel < 15) res_w[7:0] = 8'd3;
        else if (sel < 25) res_w[7:0] = 8'd128;
        else if (sel < 33) res_w[7:0] = $urandom_range(255, 129);
        else if (sel < 37) res_w[7:0] = $urandom_range(1);
        else res_w[7:0] = $urandom_range(128, 2);
        sel = $urandom_range(99);
        if (sel < 4) size_w[30:0] = '0;
        else if (sel < 14) size_w[30:0] = 31'd1;
        else if (sel < 24) size_w[30:0] = 31'h7FFF_FFFF;
        else if (sel < 40) size_w[30:0] = 31'd65536;
        else if (sel < 70) size_w[30:0] = $urandom_range(32'h0100_0000, 1);
        sel = $urandom_range(99);
        if (sel < 10) scale_w[30:0] = '0;
        else if (sel < 15) scale_w[30:0] = 31'd1;
        else if (sel < 30) scale_w[30:0] = 31'd65536;
        else if (sel < 40) scale_w[30:0] = 31'h7FFF_FFFF;
        apply_setting(res_w, size_w, scale_w);
        if ($urandom_range(9) == 0) reg_write(REG_SPARE, $urandom);
    endtask

    // queries with loads mixed in, half of the loads inside the grid in use
    task automatic run_phase(input int count);
        int unsigned rmax, row, col;
        rmax = (cur_res > MAX_RES) ? MAX_RES : ((cur_res < 1) ? 1 : cur_res);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 75) begin
                ask_height(pick_coord(cur_size), pick_coord(cur_size));
            end else if ($urandom_range(1)) begin
                row = $urandom_range(rmax - 1);
                col = $urandom_range(rmax - 1);
                load_height(row * rmax + col, $urandom);
            end else begin
                load_height($urandom, $urandom);
            end
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (choke_req) begin
                choke_req = 1'b0;
                hold_left = CHOKE_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // end the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int sent, phase, n;
        sent  = 0;
        phase = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // the store has no reset, so fill every entry first
        for (int i = 0; i < GRID_DEPTH; i++) load_height(i, $urandom);

        // corner, centre and clamped positions at the reset setting
        load_height(0, 16'hFFFF);
        load_height(1, 16'h0000);
        load_height(128, 16'h8000);
        load_height(129, 16'h0001);
        ask_height(32'hFFFF_8000, 32'h0000_8000);
        ask_height(32'h0000_0000, 32'h0000_0000);
        ask_height(32'h7FFF_FFFF, 32'h8000_0000);
        ask_height(32'h8000_0000, 32'h7FFF_FFFF);

        // two-by-two grid at the largest world and scale, full and empty heights
        apply_setting(32'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++) load_height(i, 16'hFFFF);
        ask_height(32'h0000_0000, 32'h0000_0000);
        ask_height(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++) load_height(i, 16'h0000);
        ask_height(32'h0000_0000, 32'h0000_0000);

        // resolutions below two answer zero
        apply_setting(32'd1, 32'd65536, 32'd65536);
        ask_height(32'h0000_0000, 32'h0000_0000);
        apply_setting(32'd0, 32'd65536, 32'd65536);
        ask_height(32'h1234_5678, 32'h8765_4321);

        // oversized resolution, smallest world and scale, write to a spare register
        apply_setting(32'd255, 32'd1, 32'd1);
        reg_write(REG_SPARE, 32'hFFFF_FFFF);
        ask_height(32'h0000_0000, 32'h0000_0000);
        ask_height(32'h0000_0001, 32'hFFFF_FFFF);

        // zero world size answers zero
        apply_setting(32'd3, 32'd0, 32'd65536);
        ask_height(32'h0000_0000, 32'h0000_0000);

        // random phases under random settings
        while (sent < RANDOM_ITEMS) begin
            random_setting();
            n = $urandom_range(120, 40);
            if (phase == 1) begin
                // long stretch with no idling on either side
                gap_pct   = 0;
                rx_steady = 1'b1;
                n = 300;
                run_phase(n);
                gap_pct   = IDLE_PCT;
                rx_steady = 1'b0;
            end else if (phase == 3) begin
                // receiver holds off while words keep coming
                choke_req = 1'b1;
                run_phase(n);
            end else if (phase == 5) begin
                // sender pauses until every height is back
                run_phase(n / 2);
                wait_idle();
                run_phase(n - n / 2);
            end else begin
                run_phase(n);
            end
            sent += n;
            phase++;
        end

        wait_idle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/hbs_pkg.sv
src/hbs_ram.sv
src/hbs_pos_div.sv
src/hbs_blend.sv
src/heightmap_bilinear_sampler_top.sv
sim/hbs_height_checker.sv
sim/tb_heightmap_bilinear_sampler_top.sv
